[src/dvsp_pkg.sv]
// Shared types and constants for the volume scaler with slew limit and peak detect
package dvsp_pkg;

   // Field widths
   localparam int SAMPLE_BITS    = 16;
   localparam int CODE_BITS      = 12;
   localparam int TARGET_BITS    = 12;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 12;

   // Offset-binary conversion and shifts
   localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP      = 16'h8000;
   localparam logic [SAMPLE_BITS-1:0] PEAK_LOW_RESET = 16'hFFFF;
   localparam int                     PROD_SHIFT     = 16;
   localparam int                     RAW_SHIFT      = 4;
   localparam logic [TARGET_BITS-1:0] TARGET_RESET   = 12'hFFF;

   // Function codes of an input transaction
   localparam logic FUNC_PLAY = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_VOLUME = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLUME_ENABLE = 1'b1;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [TARGET_BITS-1:0] target_volume;
      logic                   volume_enable;
   } cfg_type;

   // One result transaction
   typedef struct packed {
      logic [CODE_BITS-1:0]   dac_code;
      logic [SAMPLE_BITS-1:0] peak_span;
      logic                   peak_seen;
   } rsp_type;

endpackage

[src/dvsp_csr.sv]
// Configuration registers: target volume and volume enable
module dvsp_csr
   import dvsp_pkg::*;
#(
   parameter int VOLUME_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output cfg_type                   cfg
);

   localparam int MASK_BITS = (VOLUME_BITS < TARGET_BITS) ? VOLUME_BITS : TARGET_BITS;
   localparam logic [TARGET_BITS-1:0] TARGET_MASK =
      TARGET_BITS'((33'd1 << MASK_BITS) - 33'd1);

   logic [TARGET_BITS-1:0] target_ff, target_in;
   logic                   enable_ff, enable_in;

   assign csr_ready = 1'b1;

   // Decode the write transaction
   always_comb begin
      target_in = target_ff;
      enable_in = enable_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_VOLUME: target_in = csr_data[TARGET_BITS-1:0] & TARGET_MASK;
            CSR_VOLUME_ENABLE: enable_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET & TARGET_MASK;
         enable_ff <= 1'b1;
      end else begin
         target_ff <= target_in;
         enable_ff <= enable_in;
      end
   end

   assign cfg.target_volume = target_ff;
   assign cfg.volume_enable = enable_ff;

endmodule

[src/dvsp_core.sv]
// Datapath: volume scaling, slew step and peak tracking for one transaction
module dvsp_core
   import dvsp_pkg::*;
#(
   parameter int VOLUME_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   func,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  cfg_type                cfg,
   output rsp_type                rsp
);

   localparam int PROD_BITS = VOLUME_BITS + SAMPLE_BITS;
   localparam int CMP_BITS  = (VOLUME_BITS > TARGET_BITS) ? VOLUME_BITS : TARGET_BITS;

   logic [VOLUME_BITS-1:0] slewed_ff, slewed_in;
   logic [SAMPLE_BITS-1:0] low_ff, low_in;
   logic [SAMPLE_BITS-1:0] high_ff, high_in;

   logic [SAMPLE_BITS-1:0] unsigned_sample;
   logic [PROD_BITS-1:0]   product;
   logic [VOLUME_BITS-1:0] product_hi;
   logic [CODE_BITS-1:0]   code;
   logic [SAMPLE_BITS-1:0] track_value;
   logic [CMP_BITS-1:0]    slewed_cmp;
   logic [CMP_BITS-1:0]    target_cmp;
   logic                   seen;

   // Flip the sign bit to offset binary and scale
   assign unsigned_sample = sample ^ SIGN_FLIP;
   assign product         = PROD_BITS'(slewed_ff) * PROD_BITS'(unsigned_sample);
   assign product_hi      = product[PROD_BITS-1:PROD_SHIFT];
   assign track_value     = cfg.volume_enable ? unsigned_sample
                                              : (unsigned_sample >> RAW_SHIFT);
   assign code            = cfg.volume_enable ? CODE_BITS'(product_hi)
                                              : track_value[CODE_BITS-1:0];
   assign slewed_cmp      = CMP_BITS'(slewed_ff);
   assign target_cmp      = CMP_BITS'(cfg.target_volume);
   assign seen            = (low_ff <= high_ff);

   // Build the result and the next state
   always_comb begin
      slewed_in     = slewed_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      rsp.dac_code  = '0;
      rsp.peak_span = '0;
      rsp.peak_seen = 1'b0;
      if (func == FUNC_READ) begin
         rsp.peak_seen = seen;
         rsp.peak_span = seen ? (high_ff - low_ff) : '0;
         low_in        = PEAK_LOW_RESET;
         high_in       = '0;
      end else begin
         rsp.dac_code = code;
         if (track_value < low_ff) begin
            low_in = track_value;
         end
         if (track_value > high_ff) begin
            high_in = track_value;
         end
         // Step the slewed volume one count toward the target
         if (cfg.volume_enable) begin
            priority if (slewed_cmp < target_cmp) begin
               slewed_in = slewed_ff + 1'b1;
            end else if (slewed_cmp > target_cmp) begin
               slewed_in = slewed_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slewed_ff <= '0;
         low_ff    <= PEAK_LOW_RESET;
         high_ff   <= '0;
      end else if (advance) begin
         slewed_ff <= slewed_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
      end
   end

endmodule

[src/dac_volume_slew_peak.sv]
// Top level: input register, datapath, result register and configuration port
//
// Audio samples enter on the req_ channel (req_func selects play or peak read,
// req_sample_in is a signed 16-bit sample) and leave on the rsp_ channel, one
// result transaction per input transaction, in order. A play returns the
// 12-bit DAC code; a peak read returns the span max - min since the last read
// and whether any sample was seen, then clears the peaks.
// An accepted transaction is held in the input register; the multiply, compares
// and slew step then settle into the result register, which drives rsp_valid.
// Throughput is one transaction per cycle while the receiver does not stall,
// set by the single registered pass through the multiplier.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; req_ready drops only when both are full.
// The csr_ channel writes target_volume (index 0) and volume_enable (index 1)
// and is always ready; write it only while no transaction is in flight.
// Reset clears both registers, sets the slewed volume to zero, empties the
// peak detector and loads target_volume with full scale and volume on.
module dac_volume_slew_peak
   import dvsp_pkg::*;
#(
   parameter int VOLUME_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [CODE_BITS-1:0]      rsp_dac_code,
   output logic [SAMPLE_BITS-1:0]    rsp_peak_span,
   output logic                      rsp_peak_seen,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type cfg;
   rsp_type core_rsp;

   logic                   in_valid_ff, in_valid_in;
   logic                   func_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff;
   logic                   out_free;
   logic                   advance;

   dvsp_csr #(
      .VOLUME_BITS (VOLUME_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dvsp_core #(
      .VOLUME_BITS (VOLUME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .func    (func_ff),
      .sample  (sample_ff),
      .cfg     (cfg),
      .rsp     (core_rsp)
   );

   // Advance when the result register is empty or being drained
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
   end

   // Hold the control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff   <= req_func;
         sample_ff <= req_sample_in;
      end
      if (advance) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_dac_code  = out_ff.dac_code;
   assign rsp_peak_span = out_ff.peak_span;
   assign rsp_peak_seen = out_ff.peak_seen;

endmodule
